>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL in this folder.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/spp_pkg.sv
// Types and constants of the skeletal pose palette block.
// No dependencies; used by skeletal_pose_palette.
package spp_pkg;

   localparam int MAX_BONES  = 64;
   localparam int MAX_FRAMES = 64;
   localparam int FRAC_BITS  = 16;
   localparam int BONE_W     = $clog2(MAX_BONES);
   localparam int FRAME_W    = $clog2(MAX_FRAMES);
   localparam int COUNT_W    = 7;

   localparam logic [31:0] FIX_ONE     = 32'(1) << FRAC_BITS;
   localparam logic [31:0] DEFAULT_TPS = 32'(25) << FRAC_BITS;

   typedef enum logic [2:0] {
      MODE_TICK      = 3'd0,
      MODE_RESTART   = 3'd1,
      MODE_KEY_TIME  = 3'd2,
      MODE_LOCAL     = 3'd3,
      MODE_PARENT    = 3'd4,
      MODE_OFFSET    = 3'd5,
      MODE_READ_PAL  = 3'd6,
      MODE_READ_CLK  = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      CSR_ANIM_PRESENT = 3'd0,
      CSR_LOOP_ENABLE  = 3'd1,
      CSR_TPS          = 3'd2,
      CSR_DURATION     = 3'd3,
      CSR_BONE_COUNT   = 3'd4,
      CSR_FRAME_COUNT  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_SAT   = 2'd2
   } status_type;

endpackage

>>> rtl/core/skeletal_pose_palette.sv
// Matrix palette generator for linear blend skinning, top level.
// Depends on spp_pkg and assert_macros.svh.
//
//   channel   ports                                   direction  beat
//   request   start, busy, req_*                      in         start && !busy
//   response  rsp_valid, rsp_read_data, rsp_status    out        rsp_valid
//   csr       csr_write_enable, csr_index, csr_write_data  in    csr_write_enable
//
// Every request beat yields exactly one response beat. Loads, restart and the clock
// read answer in the next cycle; a palette read's response is formed in S_RDPAL. A
// tick updates the clock (S_MUL, S_ADD, then the S_MOD remainder when looping with a
// nonzero duration), searches the keyframes (S_FIND, S_FCMP), and per bone runs S_PAR,
// S_ROOT and two passes of S_MAT and S_DRAIN: the single shared multiplier takes one
// product per cycle through the matrix memories. busy is high throughout.
// Reset is synchronous and active high; it clears control state and the palette
// row valid bits. The receiver cannot stall; each response is shown for one cycle.
`include "assert_macros.svh"

module skeletal_pose_palette (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [2:0]               req_mode,
   input  logic [31:0]              req_delta_seconds,
   input  logic [5:0]               req_frame_index,
   input  logic [5:0]               req_bone_index,
   input  logic [3:0]               req_element_index,
   input  logic signed [31:0]       req_load_value,
   input  logic signed [6:0]        req_parent_index,
   input  logic [6:0]               req_local_count,
   output logic                     rsp_valid,
   output logic signed [31:0]       rsp_read_data,
   output logic [1:0]               rsp_status,
   input  logic                     csr_write_enable,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_write_data
);
   import spp_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_MUL   = 11'b000_0000_0010,
      S_ADD   = 11'b000_0000_0100,
      S_MOD   = 11'b000_0000_1000,
      S_FIND  = 11'b000_0001_0000,
      S_FCMP  = 11'b000_0010_0000,
      S_PAR   = 11'b000_0100_0000,
      S_ROOT  = 11'b000_1000_0000,
      S_MAT   = 11'b001_0000_0000,
      S_DRAIN = 11'b010_0000_0000,
      S_RDPAL = 11'b100_0000_0000
   } state_type;

   // Configuration registers.
   logic        anim_present_ff, loop_enable_ff;
   logic [31:0] tps_ff, duration_ff;
   logic [6:0]  bone_count_ff, frame_count_ff;

   // Control and datapath registers.
   state_type   state_ff, state_in;
   logic [31:0] clock_ff, clock_in;
   logic [31:0] dt_ff, dt_in;
   logic        sat_ff, sat_in;
   logic [48:0] div_num_ff, div_num_in;
   logic [31:0] div_rem_ff, div_rem_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;
   logic [FRAME_W-1:0] f_ff, f_in, idx_ff, idx_in;
   logic [6:0]  cnt_ff, cnt_in, prev_cnt_ff, prev_cnt_in;
   logic [BONE_W-1:0] b_ff, b_in, par_ff, par_in;
   logic        root_ff, root_in;
   logic        phase_ff, phase_in;
   logic [5:0]  c_ff, c_in, c1_ff, c2_ff;
   logic        v1_ff, v1_in, v2_ff;
   logic [64:0] prod_ff;
   logic signed [65:0] acc_ff, acc_in;
   logic [MAX_BONES-1:0] pal_vld_ff, pal_vld_in;
   logic        rd_hit_ff, rd_hit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // Memories and their registered read data.
   logic [38:0] key_mem [MAX_FRAMES];
   logic [6:0]  par_mem [MAX_BONES];
   logic [31:0] loc_mem [MAX_FRAMES*MAX_BONES*16];
   logic [31:0] off_mem [MAX_BONES*16];
   logic [31:0] glb_mem [MAX_BONES*16];
   logic [31:0] pal_mem [MAX_BONES*16];
   logic [38:0] key_rd_ff;
   logic [6:0]  par_rd_ff;
   logic [31:0] loc_rd_ff, off_rd_ff, glb_rd_ff, pal_rd_ff;

   logic        accept;
   logic [6:0]  nb, nf;
   logic [31:0] tps_eff;
   logic [48:0] adv_sum;
   logic [32:0] div_try;
   logic [32:0] div_next;
   logic        key_later;
   logic [BONE_W+3:0] glb_raddr;
   logic [31:0] op_a, op_b;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic signed [49:0] acc_shift;
   logic        acc_hi, acc_lo, wr_elem;
   logic [31:0] acc_val;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;

   assign nb      = (bone_count_ff  > 7'(MAX_BONES))  ? 7'(MAX_BONES)  : bone_count_ff;
   assign nf      = (frame_count_ff > 7'(MAX_FRAMES)) ? 7'(MAX_FRAMES) : frame_count_ff;
   assign tps_eff = (tps_ff == 32'd0) ? DEFAULT_TPS : tps_ff;
   assign adv_sum = {17'd0, clock_ff} + {1'b0, prod_ff[63:FRAC_BITS]};

   // One step of the restoring remainder: shift in one dividend bit, subtract if it fits.
   assign div_try  = {div_rem_ff, div_num_ff[48]};
   assign div_next = (div_try >= {1'b0, duration_ff}) ? div_try - {1'b0, duration_ff}
                                                       : div_try;

   // A negative key time never lies after the unsigned clock.
   assign key_later = !key_rd_ff[31] && (key_rd_ff[31:0] > clock_ff);

   // Phase 0 reads the parent's global row, phase 1 the bone's own row.
   assign glb_raddr = phase_ff ? {b_ff, c_ff[1:0], c_ff[3:2]}
                               : {par_ff, c_ff[1:0], c_ff[3:2]};

   // Operands for the product now in flight (tag c1: column, row, k).
   always_comb begin
      if (phase_ff) begin
         op_a = glb_rd_ff;
         op_b = off_rd_ff;
      end else begin
         op_a = root_ff ? ((c1_ff[3:2] == c1_ff[1:0]) ? FIX_ONE : 32'd0) : glb_rd_ff;
         op_b = ({1'b0, b_ff} < cnt_ff) ? loc_rd_ff
                                        : ((c1_ff[5:4] == c1_ff[1:0]) ? FIX_ONE : 32'd0);
      end
   end

   // The one multiplier serves the clock advance (unsigned) and the matrix products.
   assign mul_a = v1_ff ? $signed({op_a[31], op_a}) : $signed({1'b0, dt_ff});
   assign mul_b = v1_ff ? $signed({op_b[31], op_b}) : $signed({1'b0, tps_eff});
   assign mul_p = mul_a * mul_b;

   // Accumulate four products, floor by the fraction bits, saturate to 32 bits.
   assign acc_in    = ((c2_ff[1:0] == 2'd0) ? 66'sd0 : acc_ff)
                      + $signed({prod_ff[64], prod_ff});
   assign acc_shift = acc_in[65:FRAC_BITS];
   assign acc_hi    = !acc_shift[49] && (|acc_shift[48:31]);
   assign acc_lo    = acc_shift[49] && !(&acc_shift[48:31]);
   assign acc_val   = acc_hi ? 32'h7FFF_FFFF : (acc_lo ? 32'h8000_0000 : acc_shift[31:0]);
   assign wr_elem   = v2_ff && (c2_ff[1:0] == 2'd3);

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clock_in      = clock_ff;
      dt_in         = dt_ff;
      sat_in        = sat_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;
      f_in          = f_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      prev_cnt_in   = prev_cnt_ff;
      b_in          = b_ff;
      par_in        = par_ff;
      root_in       = root_ff;
      phase_in      = phase_ff;
      c_in          = c_ff;
      v1_in         = 1'b0;
      pal_vld_in    = pal_vld_ff;
      rd_hit_in     = rd_hit_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = 32'd0;
      rsp_status_in = STAT_OK;

      if (wr_elem) begin
         sat_in = sat_ff || acc_hi || acc_lo;
         if (phase_ff) begin
            pal_vld_in[b_ff] = 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (mode_type'(req_mode))
                  MODE_TICK: begin
                     if (anim_present_ff) begin
                        dt_in    = req_delta_seconds;
                        sat_in   = 1'b0;
                        state_in = S_MUL;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  MODE_RESTART: begin
                     clock_in     = 32'd0;
                     pal_vld_in   = '0;
                     rsp_valid_in = 1'b1;
                  end
                  MODE_READ_PAL: begin
                     rd_hit_in = ({1'b0, req_bone_index} < nb);
                     state_in  = S_RDPAL;
                  end
                  MODE_READ_CLK: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = clock_ff;
                  end
                  default: begin
                     // Loads: every 6-bit index is inside the stores.
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (loop_enable_ff && (duration_ff != 32'd0)) begin
               div_num_in = adv_sum;
               div_rem_in = 32'd0;
               div_cnt_in = 6'd49;
               state_in   = S_MOD;
            end else begin
               if (adv_sum[48:32] != 17'd0) begin
                  clock_in = 32'hFFFF_FFFF;
                  sat_in   = 1'b1;
               end else begin
                  clock_in = adv_sum[31:0];
               end
               f_in     = '0;
               state_in = S_FIND;
            end
         end
         S_MOD: begin
            div_rem_in = div_next[31:0];
            div_num_in = {div_num_ff[47:0], 1'b0};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd1) begin
               clock_in = div_next[31:0];
               f_in     = '0;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            if (nf == 7'd0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sat_ff ? STAT_SAT : STAT_OK;
               state_in      = S_IDLE;
            end else begin
               state_in = S_FCMP;
            end
         end
         S_FCMP: begin
            prev_cnt_in = key_rd_ff[38:32];
            if (key_later || ({1'b0, f_ff} == nf - 7'd1)) begin
               if (key_later && (f_ff != '0)) begin
                  idx_in = f_ff - FRAME_W'(1);
                  cnt_in = prev_cnt_ff;
               end else begin
                  idx_in = f_ff;
                  cnt_in = key_rd_ff[38:32];
               end
               b_in = '0;
               if (nb == 7'd0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = sat_ff ? STAT_SAT : STAT_OK;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_PAR;
               end
            end else begin
               f_in     = f_ff + FRAME_W'(1);
               state_in = S_FIND;
            end
         end
         S_PAR: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            // A parent that is negative or not below this bone makes it a root.
            root_in  = par_rd_ff[6] || (par_rd_ff[5:0] >= b_ff);
            par_in   = par_rd_ff[5:0];
            phase_in = 1'b0;
            c_in     = 6'd0;
            state_in = S_MAT;
         end
         S_MAT: begin
            v1_in = 1'b1;
            c_in  = c_ff + 6'd1;
            if (c_ff == 6'd63) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  c_in     = 6'd0;
                  state_in = S_MAT;
               end else if ({1'b0, b_ff} == nb - 7'd1) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = sat_ff ? STAT_SAT : STAT_OK;
                  state_in      = S_IDLE;
               end else begin
                  b_in     = b_ff + BONE_W'(1);
                  state_in = S_PAR;
               end
            end
         end
         S_RDPAL: begin
            rsp_valid_in = 1'b1;
            if (!rd_hit_ff) begin
               rsp_status_in = STAT_RANGE;
            end else begin
               rsp_data_in = pal_vld_ff[b_ff] ? pal_rd_ff : 32'd0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // The palette read row is latched in b_ff so the valid bit can be checked.
      if (accept && (mode_type'(req_mode) == MODE_READ_PAL)) begin
         b_in = req_bone_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         anim_present_ff <= 1'b0;
         loop_enable_ff  <= 1'b0;
         tps_ff          <= 32'd0;
         duration_ff     <= 32'd0;
         bone_count_ff   <= 7'd0;
         frame_count_ff  <= 7'd0;
         clock_ff        <= 32'd0;
         pal_vld_ff      <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clock_ff     <= clock_in;
         pal_vld_ff   <= pal_vld_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_ANIM_PRESENT: anim_present_ff <= csr_write_data[0];
               CSR_LOOP_ENABLE:  loop_enable_ff  <= csr_write_data[0];
               CSR_TPS:          tps_ff          <= csr_write_data;
               CSR_DURATION:     duration_ff     <= csr_write_data;
               CSR_BONE_COUNT:   bone_count_ff   <= csr_write_data[6:0];
               CSR_FRAME_COUNT:  frame_count_ff  <= csr_write_data[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dt_ff         <= dt_in;
      sat_ff        <= sat_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_cnt_ff    <= div_cnt_in;
      f_ff          <= f_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      prev_cnt_ff   <= prev_cnt_in;
      b_ff          <= b_in;
      par_ff        <= par_in;
      root_ff       <= root_in;
      phase_ff      <= phase_in;
      c_ff          <= c_in;
      c1_ff         <= c_ff;
      c2_ff         <= c1_ff;
      prod_ff       <= mul_p[64:0];
      acc_ff        <= acc_in;
      rd_hit_ff     <= rd_hit_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Load stores, written on the request beat.
   always_ff @(posedge clock) begin
      if (accept && (mode_type'(req_mode) == MODE_KEY_TIME)) begin
         key_mem[req_frame_index] <= {req_local_count, req_load_value};
      end
      key_rd_ff <= key_mem[f_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && (mode_type'(req_mode) == MODE_PARENT)) begin
         par_mem[req_bone_index] <= req_parent_index;
      end
      par_rd_ff <= par_mem[b_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && (mode_type'(req_mode) == MODE_LOCAL)) begin
         loc_mem[{req_frame_index, req_bone_index, req_element_index}] <= req_load_value;
      end
      loc_rd_ff <= loc_mem[{idx_ff, b_ff, c_ff[5:4], c_ff[1:0]}];
   end

   always_ff @(posedge clock) begin
      if (accept && (mode_type'(req_mode) == MODE_OFFSET)) begin
         off_mem[{req_bone_index, req_element_index}] <= req_load_value;
      end
      off_rd_ff <= off_mem[{b_ff, c_ff[5:4], c_ff[1:0]}];
   end

   // Global and palette rows are written as each element's sum completes.
   always_ff @(posedge clock) begin
      if (wr_elem && !phase_ff) begin
         glb_mem[{b_ff, c2_ff[5:2]}] <= acc_val;
      end
      glb_rd_ff <= glb_mem[glb_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_elem && phase_ff) begin
         pal_mem[{b_ff, c2_ff[5:2]}] <= acc_val;
      end
      pal_rd_ff <= pal_mem[{req_bone_index, req_element_index}];
   end

   `ASSERT_SAME(a_idle_pipe_empty, clock, reset, (state_ff == S_IDLE), (!v1_ff && !v2_ff), "matrix pipeline active while idle")
   `ASSERT_SAME(a_write_in_walk, clock, reset, v2_ff, (state_ff == S_MAT || state_ff == S_DRAIN), "element written outside the bone walk")
   `ASSERT_NEXT(a_load_answers, clock, reset, (accept && req_mode != MODE_TICK && req_mode != MODE_READ_PAL), rsp_valid, "load or clock read not answered next cycle")
   `ASSERT_SAME(a_mod_needs_loop, clock, reset, (state_ff == S_MOD), (loop_enable_ff && duration_ff != 32'd0), "clock wrap without looping")
   `ASSERT_SAME(a_resp_idle, clock, reset, rsp_valid, (state_ff == S_IDLE || $past(accept)), "response while an item is still at work")

endmodule
